>>> rtl/gmf_pkg.sv
// Shared types and constants for the gated mode filter.
package gmf_pkg;

  localparam int DATA_W    = 16;   // distance width
  localparam int SC_W      = 7;    // sample_count register width
  localparam int BIN_AW    = 8;    // histogram address width
  localparam int BIN_DEPTH = 256;  // histogram entries
  localparam int APB_AW    = 3;    // byte address, two 32-bit registers
  localparam int APB_DW    = 32;

  // Register index codes (paddr[2])
  localparam logic REG_CENTER       = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  // Configuration view handed from the register file to the datapath
  typedef struct packed {
    logic [DATA_W-1:0] lo;            // saturated lower window bound
    logic [DATA_W-1:0] hi;            // saturated upper window bound
    logic [SC_W-1:0]   sample_count;  // raw register value
    logic              wr;            // any register written this cycle
  } gmf_cfg_t;

endpackage

>>> rtl/gated_mode_filter.sv
// Top level of the gated mode filter: window gate, histogram stage, result register.
//
// Range samples are gated against center_distance +/- HALF_WINDOW (both bounds
// saturate at 0 and 65535); samples outside the window are accepted and
// dropped without effect. Each in-window sample bumps its histogram bin and
// the running leader, which changes only on a strictly higher count, so a tie
// goes to the value that reached the maximum first. After sample_count
// in-window samples (zero acts as one, values above MAX_SAMPLES act as
// MAX_SAMPLES) the leader is emitted as mode_distance and a new window starts.
// Rate: one sample per clock unless stalled. A sample is registered together with
// the registered read of its bin; the bin is rewritten in the next cycle,
// and a count written in the same cycle as the next read is forwarded. The
// result of a window enters the output register as its last sample leaves the
// histogram stage, which waits for a free output side, and out_valid rises with
// it; input stalls only when a window closes while an earlier result
// still waits in the output register. The 256-entry histogram lives in a RAM whose
// entries are qualified by flip-flop valid bits cleared all at once, so
// there is no clearing pass after reset or between windows. Any write to a
// register discards the window in progress; write registers only while idle.
module gated_mode_filter #(
  parameter int MAX_SAMPLES = 64,
  parameter int HALF_WINDOW = 70
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gmf_pkg::DATA_W-1:0]  in_sample_distance,
  // result requests
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gmf_pkg::DATA_W-1:0]  out_mode_distance,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gmf_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [gmf_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [gmf_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import gmf_pkg::*;

  gmf_cfg_t          cfg;
  logic              in_win;
  logic [DATA_W-1:0] offset;
  logic              load;
  logic              s1_ready;
  logic              res_vld;
  logic [DATA_W-1:0] res_mode;
  logic              slot_free;
  logic              out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0] out_mode_r;

  gmf_regs #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Gate the sample against the saturated window; offset from the lower
  // bound addresses the histogram (window is at most 255 wide).
  assign in_win = (in_sample_distance >= cfg.lo) && (in_sample_distance <= cfg.hi);
  assign offset = in_sample_distance - cfg.lo;

  // Accept whenever the histogram stage can move; out-of-window samples drop here.
  assign in_ready = s1_ready;
  assign load     = in_valid & in_ready & in_win;

  gmf_hist #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .load       (load),
    .load_idx   (offset[BIN_AW-1:0]),
    .load_value (in_sample_distance),
    .slot_free  (slot_free),
    .s1_ready   (s1_ready),
    .res_vld    (res_vld),
    .res_mode   (res_mode)
  );

  // Output register: free when empty or being drained this cycle.
  assign slot_free = ~out_vld_r | out_ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_mode_r <= res_mode;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_mode_distance = out_mode_r;

  // A closing window never overwrites a result still waiting.
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (!out_vld_r || out_ready))
    else $error("window result produced while output register held");

  // A closing window shows up in the output register next cycle.
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (out_vld_r && out_mode_r == $past(res_mode)))
    else $error("window result lost on the way to the output");

  // The user writes only while idle (not enforced here), so no result follows.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.wr |=> !res_vld)
    else $error("result produced right after a register write");

endmodule

>>> rtl/gmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/gmf_regs.sv
// Configuration register file with precomputed window bounds.
module gmf_regs #(
  parameter int HALF_WINDOW = 70
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gmf_pkg::APB_AW-1:0]   paddr,
  input  logic [gmf_pkg::APB_DW-1:0]   pwdata,
  output logic [gmf_pkg::APB_DW-1:0]   prdata,
  output gmf_pkg::gmf_cfg_t            cfg
);
  import gmf_pkg::*;

  localparam logic [DATA_W-1:0] HW = DATA_W'(HALF_WINDOW);

  logic [DATA_W-1:0] center_r, center_nxt;
  logic [SC_W-1:0]   sc_r, sc_nxt;
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic [DATA_W:0]   hi_sum;
  logic              we;
  logic              reg_sel;

  assign we      = psel & penable & pwrite;
  assign reg_sel = paddr[2];
  assign hi_sum  = {1'b0, pwdata[DATA_W-1:0]} + {1'b0, HW};

  always_comb begin
    center_nxt = center_r;
    sc_nxt     = sc_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    if (we) begin
      case (reg_sel)
        REG_CENTER: begin
          center_nxt = pwdata[DATA_W-1:0];
          // saturate both bounds to the distance range
          lo_nxt = (pwdata[DATA_W-1:0] >= HW) ? pwdata[DATA_W-1:0] - HW : '0;
          hi_nxt = hi_sum[DATA_W] ? '1 : hi_sum[DATA_W-1:0];
        end
        REG_SAMPLE_COUNT: begin
          sc_nxt = pwdata[SC_W-1:0];
        end
        default: begin
          center_nxt = center_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      sc_r     <= SC_W'(1);
      lo_r     <= '0;
      hi_r     <= HW;
    end else begin
      center_r <= center_nxt;
      sc_r     <= sc_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
    end
  end

  assign prdata = (reg_sel == REG_SAMPLE_COUNT) ? APB_DW'(sc_r) : APB_DW'(center_r);

  assign cfg.lo           = lo_r;
  assign cfg.hi           = hi_r;
  assign cfg.sample_count = sc_r;
  assign cfg.wr           = we;

endmodule

>>> rtl/gmf_hist.sv
// Histogram stage: bin update with forwarding, leader tracking, window close.
module gmf_hist #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gmf_pkg::gmf_cfg_t           cfg,
  input  logic                        load,      // in-window sample accepted
  input  logic [gmf_pkg::BIN_AW-1:0]  load_idx,
  input  logic [gmf_pkg::DATA_W-1:0]  load_value,
  input  logic                        slot_free, // output register can take a result
  output logic                        s1_ready,
  output logic                        res_vld,
  output logic [gmf_pkg::DATA_W-1:0]  res_mode
);
  import gmf_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic                 s1_vld_r;
  logic [BIN_AW-1:0]    s1_idx_r;
  logic [DATA_W-1:0]    s1_val_r;
  logic                 fwd_hit_r;
  logic [CW-1:0]        fwd_cnt_r;
  logic [BIN_DEPTH-1:0] bin_vld_r;
  logic [CW-1:0]        acc_r, acc_nxt;
  logic [CW-1:0]        best_cnt_r, best_cnt_nxt;
  logic [DATA_W-1:0]    best_val_r, best_val_nxt;

  logic [CW-1:0]        rd_data;
  logic [CW-1:0]        cur_cnt;
  logic [CW-1:0]        cnt_new;
  logic [CW-1:0]        acc_new;
  logic [CW-1:0]        tgt;
  logic                 done;
  logic                 lead;
  logic                 adv;
  logic                 clr;

  gmf_ram #(
    .WIDTH (CW),
    .DEPTH (BIN_DEPTH)
  ) u_bins (
    .clk     (clk),
    .wr_en   (adv & ~done),
    .wr_addr (s1_idx_r),
    .wr_data (cnt_new),
    .rd_en   (load),
    .rd_addr (load_idx),
    .rd_data (rd_data)
  );

  // window target: zero means one, clamp to MAX_SAMPLES
  always_comb begin
    if (cfg.sample_count == '0) begin
      tgt = CW'(1);
    end else if (32'(cfg.sample_count) > MAX_SAMPLES) begin
      tgt = CW'(MAX_SAMPLES);
    end else begin
      tgt = CW'(cfg.sample_count);
    end
  end

  // take the count just written when the read raced it; invalid bins read zero
  assign cur_cnt = fwd_hit_r ? fwd_cnt_r : (bin_vld_r[s1_idx_r] ? rd_data : '0);
  assign cnt_new = cur_cnt + CW'(1);
  assign acc_new = acc_r + CW'(1);
  assign done    = (acc_new >= tgt);
  assign lead    = (cnt_new > best_cnt_r);

  assign adv      = s1_vld_r & (~done | slot_free);
  assign s1_ready = ~s1_vld_r | adv;
  assign clr      = cfg.wr | (adv & done);

  assign res_vld  = adv & done;
  assign res_mode = lead ? s1_val_r : best_val_r;

  always_comb begin
    acc_nxt      = acc_r;
    best_cnt_nxt = best_cnt_r;
    best_val_nxt = best_val_r;
    if (clr) begin
      acc_nxt      = '0;
      best_cnt_nxt = '0;
      best_val_nxt = '0;
    end else if (adv) begin
      acc_nxt = acc_new;
      if (lead) begin
        best_cnt_nxt = cnt_new;
        best_val_nxt = s1_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
      bin_vld_r  <= '0;
      acc_r      <= '0;
      best_cnt_r <= '0;
      best_val_r <= '0;
    end else begin
      acc_r      <= acc_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_val_r <= best_val_nxt;
      if (load) begin
        s1_vld_r  <= 1'b1;
        fwd_hit_r <= adv & ~done & (s1_idx_r == load_idx);
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (clr) begin
        bin_vld_r <= '0;
      end else if (adv) begin
        bin_vld_r[s1_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_idx_r  <= load_idx;
      s1_val_r  <= load_value;
      fwd_cnt_r <= cnt_new;
    end
  end

endmodule
